[rtl/sgsq_pkg.sv]
// Shared types and codes of the session-gated sample queue.
// No dependencies; sgsq_if, sgsq_ctrl and the top level import this package.
package sgsq_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [2:0] {
    KindStart   = 3'd0,
    KindStop    = 3'd1,
    KindHeader  = 3'd2,
    KindElement = 3'd3,
    KindTake    = 3'd4
  } kind_e;

  // Result status codes; the fault register uses the same codes.
  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusStale     = 3'd1,
    StatusBadAcq    = 3'd2,
    StatusOverflow  = 3'd3,
    StatusExhausted = 3'd4,
    StatusBusy      = 3'd5
  } status_e;

  localparam int unsigned SessionW = 32;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned CountW   = 8;

  // Result of one item, minus the sample value that comes from the store.
  typedef struct packed {
    logic              accepted;
    status_e           status;
    logic [SeqW-1:0]   seq_num;
    status_e           fault;
    logic              take_ok;
  } resp_t;

endpackage

[rtl/sgsq_if.sv]
// Valid/ready channel interfaces of the session-gated sample queue.
// Depends on sgsq_pkg for field widths.
interface sgsq_in_if #(
  parameter int unsigned SampleWidth = 48
);
  import sgsq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [2:0]             kind;
  logic [SessionW-1:0]    session;
  logic [SessionW-1:0]    acquisition;
  logic [CountW-1:0]      batch_count;
  logic                   verified;
  logic [SampleWidth-1:0] sample_value;

  modport source (
    output valid, kind, session, acquisition, batch_count, verified, sample_value,
    input  ready
  );
  modport sink (
    input  valid, kind, session, acquisition, batch_count, verified, sample_value,
    output ready
  );
endinterface

interface sgsq_out_if #(
  parameter int unsigned SampleWidth = 48
);
  import sgsq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic [2:0]             status;
  logic [SeqW-1:0]        out_sequence;
  logic [SampleWidth-1:0] out_value;
  logic [2:0]             latched_fault;

  modport source (
    output valid, accepted, status, out_sequence, out_value, latched_fault,
    input  ready
  );
  modport sink (
    input  valid, accepted, status, out_sequence, out_value, latched_fault,
    output ready
  );
endinterface

[rtl/sgsq_store.sv]
// Sample memory: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module sgsq_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 48,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/sgsq_ctrl.sv]
// Session control: session, sequence and ring pointers, header checks.
// Depends on sgsq_pkg; drives the write and read ports of sgsq_store.
module sgsq_ctrl #(
  parameter int unsigned QueueDepth  = 16,
  parameter int unsigned SampleWidth = 48,
  parameter int unsigned SlotW       = 4,
  parameter int unsigned FillW       = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_accept_i,
  input  logic [2:0]                kind_i,
  input  logic [sgsq_pkg::SessionW-1:0] session_i,
  input  logic [sgsq_pkg::SessionW-1:0] acquisition_i,
  input  logic [sgsq_pkg::CountW-1:0]   batch_count_i,
  input  logic                      verified_i,
  input  logic [SampleWidth-1:0]    sample_value_i,
  output logic                      wr_en_o,
  output logic [SlotW-1:0]          wr_addr_o,
  output logic [SampleWidth-1:0]    wr_data_o,
  output logic                      rd_en_o,
  output logic [SlotW-1:0]          rd_addr_o,
  output sgsq_pkg::resp_t           resp_o
);
  import sgsq_pkg::*;

  localparam int unsigned SumW = FillW + 1;
  localparam int unsigned CmpW = CountW + 1;
  localparam logic [CmpW-1:0]  DepthCmp  = CmpW'(QueueDepth);
  localparam logic [FillW-1:0] DepthFill = FillW'(QueueDepth);
  localparam logic [SumW-1:0]  DepthSum  = SumW'(QueueDepth);
  localparam logic [SlotW-1:0] LastSlot  = SlotW'(QueueDepth - 1);

  logic                running_q, running_d;
  logic [SessionW-1:0] session_q, session_d;
  logic [SessionW-1:0] last_acq_q, last_acq_d;
  logic [SeqW-1:0]     next_seq_q, next_seq_d;
  logic [SlotW-1:0]    read_slot_q, read_slot_d;
  logic [FillW-1:0]    fill_q, fill_d;
  status_e             fault_q, fault_d;
  logic [FillW-1:0]    pending_q, pending_d;

  logic [SumW-1:0]     wr_sum;
  logic [SumW-1:0]     wr_wrap;
  logic [CmpW-1:0]     room;
  logic                bad_batch;
  logic                session_ok;

  // Ring slot of the next append: read_slot + fill, wrapped once.
  assign wr_sum  = SumW'(read_slot_q) + SumW'(fill_q);
  assign wr_wrap = (wr_sum >= DepthSum) ? (wr_sum - DepthSum) : wr_sum;
  assign room    = DepthCmp - CmpW'(fill_q);

  assign session_ok = running_q && (session_i == session_q);
  assign bad_batch  = !verified_i || (batch_count_i == '0)
                   || (CmpW'(batch_count_i) > DepthCmp)
                   || ((acquisition_i - last_acq_q) != SessionW'(1));

  always_comb begin
    running_d   = running_q;
    session_d   = session_q;
    last_acq_d  = last_acq_q;
    next_seq_d  = next_seq_q;
    read_slot_d = read_slot_q;
    fill_d      = fill_q;
    fault_d     = fault_q;
    pending_d   = pending_q;
    wr_en_o     = 1'b0;
    rd_en_o     = 1'b0;
    resp_o.accepted = 1'b0;
    resp_o.status   = StatusBusy;
    resp_o.seq_num  = '0;
    resp_o.take_ok  = 1'b0;

    if (kind_i == KindElement) begin
      if ((pending_q != '0) && (fill_q < DepthFill)) begin
        wr_en_o   = item_accept_i;
        fill_d    = fill_q + FillW'(1);
        pending_d = pending_q - FillW'(1);
        resp_o.accepted = 1'b1;
        resp_o.status   = StatusOk;
      end
    end else if (pending_q == '0) begin
      unique case (kind_i)
        KindStart: begin
          if (running_q) begin
            resp_o.status = StatusBusy;
          end else if ((session_i == '0) || (session_i <= session_q)) begin
            resp_o.status = StatusStale;
          end else begin
            session_d   = session_i;
            last_acq_d  = acquisition_i;
            next_seq_d  = '0;
            read_slot_d = '0;
            fill_d      = '0;
            fault_d     = StatusOk;
            running_d   = 1'b1;
            resp_o.accepted = 1'b1;
            resp_o.status   = StatusOk;
          end
        end
        KindStop: begin
          if (session_i == session_q) begin
            running_d   = 1'b0;
            read_slot_d = '0;
            fill_d      = '0;
            resp_o.accepted = 1'b1;
            resp_o.status   = StatusOk;
          end else begin
            resp_o.status = StatusStale;
          end
        end
        KindHeader: begin
          priority if (!session_ok) begin
            resp_o.status = StatusStale;
          end else if (bad_batch) begin
            resp_o.status = StatusBadAcq;
          end else if (CmpW'(batch_count_i) > room) begin
            resp_o.status = StatusOverflow;
          end else if (SeqW'(batch_count_i) > ~next_seq_q) begin
            resp_o.status = StatusExhausted;
          end else begin
            next_seq_d = next_seq_q + SeqW'(batch_count_i);
            last_acq_d = acquisition_i;
            pending_d  = FillW'(batch_count_i);
            resp_o.accepted = 1'b1;
            resp_o.status   = StatusOk;
          end
          // Any failure past the session check stops the session.
          if (session_ok && !resp_o.accepted) begin
            running_d   = 1'b0;
            read_slot_d = '0;
            fill_d      = '0;
            fault_d     = resp_o.status;
          end
        end
        KindTake: begin
          if (!session_ok) begin
            resp_o.status = StatusStale;
          end else if (fill_q == '0) begin
            resp_o.status = StatusBusy;
          end else begin
            rd_en_o     = item_accept_i;
            read_slot_d = (read_slot_q == LastSlot) ? '0 : read_slot_q + SlotW'(1);
            fill_d      = fill_q - FillW'(1);
            resp_o.accepted = 1'b1;
            resp_o.status   = StatusOk;
            resp_o.seq_num  = next_seq_q - SeqW'(fill_q) + SeqW'(1);
            resp_o.take_ok  = 1'b1;
          end
        end
        default: begin
          resp_o.status = StatusBusy;
        end
      endcase
    end

    resp_o.fault = fault_d;
  end

  assign wr_addr_o = SlotW'(wr_wrap);
  assign wr_data_o = sample_value_i;
  assign rd_addr_o = read_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      session_q   <= '0;
      last_acq_q  <= '0;
      next_seq_q  <= '0;
      read_slot_q <= '0;
      fill_q      <= '0;
      fault_q     <= StatusOk;
      pending_q   <= '0;
    end else if (item_accept_i) begin
      running_q   <= running_d;
      session_q   <= session_d;
      last_acq_q  <= last_acq_d;
      next_seq_q  <= next_seq_d;
      read_slot_q <= read_slot_d;
      fill_q      <= fill_d;
      fault_q     <= fault_d;
      pending_q   <= pending_d;
    end
  end

endmodule

[rtl/session_gated_sample_queue_core.sv]
// Top level of the session-gated sample queue: control, sample store, result pipe.
// Depends on sgsq_pkg, sgsq_if, sgsq_ctrl and sgsq_store.
//
//   channel  dir  modport        carries
//   in_i     in   sgsq_in_if     kind, session, acquisition, batch_count, verified, sample
//   out_o    out  sgsq_out_if    accepted, status, out_sequence, out_value, latched_fault
//
// One word enters per cycle while in_i.ready is high; each gives one result word
// through state update at accept, store read, then the output register.
// Every word passes the read stage, take or not, so the latency is the same
// for all kinds; the stage only exists to wait for the store read data.
// Reset clears session, pointers, fault and pipe valid bits; the store is
// not cleared, since a take only reads written entries.
// A stalled output holds the pipe, and in_i.ready falls only when both
// the read stage and the output register are full and not drained.
module session_gated_sample_queue_core #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned SAMPLE_WIDTH = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgsq_in_if.sink    in_i,
  sgsq_out_if.source out_o
);
  import sgsq_pkg::*;

  localparam int unsigned SlotW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);

  logic                    in_accept;
  logic                    in_ready;
  logic                    s1_adv;
  logic                    wr_en;
  logic [SlotW-1:0]        wr_addr;
  logic [SAMPLE_WIDTH-1:0] wr_data;
  logic                    rd_en;
  logic [SlotW-1:0]        rd_addr;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  resp_t                   resp;

  // Read stage: the result waits here for the store data.
  logic                    s1_valid_q;
  resp_t                   s1_meta_q;

  // Output register.
  logic                    out_valid_q;
  resp_t                   out_meta_q;
  logic [SAMPLE_WIDTH-1:0] out_value_q;

  // Advance the read stage whenever the output register is free or draining.
  assign s1_adv    = !out_valid_q || out_o.ready;
  assign in_ready  = !s1_valid_q || s1_adv;
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  sgsq_ctrl #(
    .QueueDepth  (QUEUE_DEPTH),
    .SampleWidth (SAMPLE_WIDTH),
    .SlotW       (SlotW),
    .FillW       (FillW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_accept_i  (in_accept),
    .kind_i         (in_i.kind),
    .session_i      (in_i.session),
    .acquisition_i  (in_i.acquisition),
    .batch_count_i  (in_i.batch_count),
    .verified_i     (in_i.verified),
    .sample_value_i (in_i.sample_value),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .resp_o         (resp)
  );

  sgsq_store #(
    .Depth (QUEUE_DEPTH),
    .Width (SAMPLE_WIDTH),
    .AddrW (SlotW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Pipe valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Pipe payload: capture on accept, move on advance.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_meta_q <= resp;
    end
    if (s1_adv && s1_valid_q) begin
      out_meta_q  <= s1_meta_q;
      out_value_q <= s1_meta_q.take_ok ? rd_data : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accepted      = out_meta_q.accepted;
  assign out_o.status        = out_meta_q.status;
  assign out_o.out_sequence  = out_meta_q.seq_num;
  assign out_o.out_value     = out_value_q;
  assign out_o.latched_fault = out_meta_q.fault;

  // A waiting read-stage word must hold until the output register frees.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_meta_q)))
    else $error("read stage word lost or changed while stalled");

  // A store read is issued only for an accepted word.
  a_rd_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> in_accept)
    else $error("store read without an accepted word");

  // Only an accepted take carries a sample value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_meta_q.take_ok) |-> (out_value_q == '0))
    else $error("sample value on a result that is not a take");

endmodule
